### src/gffsa_pkg.sv
// gffsa_pkg: shared types and constants of the grid first-fit slot allocator
`default_nettype none
package gffsa_pkg;

    localparam int unsigned NUM_COLS       = 2;
    localparam int unsigned MAX_HEIGHT     = 8;
    localparam int unsigned DEFAULT_HEIGHT = 4;
    localparam int unsigned SNAP_ROWS      = 8;
    localparam int unsigned SPAN_W         = 5;

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_FIND    = 2'd1,
        FUNC_RESERVE = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } state_t;

    typedef logic [1:0] cells_t;

endpackage
`default_nettype wire

### src/grid_first_fit_slot_allocator.sv
// grid_first_fit_slot_allocator: two-column occupancy map with first-fit find and reserve
//
// input channel in_valid/in_ready carries one operation item: clear, find or reserve.
// output channel out_valid/out_ready returns one result item per operation.
// the map sits in a circular row shift register that moves one row per cycle, while a find
// scans or a run is marked, past a single head cell; find scans it in one full turn, marking
// takes another turn. clear and unused codes go from accept straight to the done state; a
// reserve with valid bounds makes a marking turn (else it goes straight to done), a find
// makes a scan turn, and a find that hits with reserve_on_find set then also makes a marking
// turn. the next item can be accepted in the same cycle that out_valid rises.
// one operation is in the map at a time; in_ready is high whenever the map is idle,
// even while a finished result still sits in the output register.
// a stalled receiver holds out_valid and the result; a following operation runs to
// completion and then waits until the output register is free.
// reset (rst_n low, asynchronous) frees every cell and empties the output register.
`default_nettype none
module grid_first_fit_slot_allocator
    import gffsa_pkg::*;
#(
    parameter int unsigned ROWS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [1:0]  req_columns,
    input  wire logic [3:0]  req_rows,
    input  wire logic        reserve_on_find,
    input  wire logic        col_first,
    input  wire logic        col_last,
    input  wire logic [2:0]  row_first,
    input  wire logic [2:0]  row_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [1:0]       out_column,
    output logic [3:0]       out_row,
    output logic [15:0]      map_snapshot
);

    localparam int unsigned CNT_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned SNAP_N = (ROWS < SNAP_ROWS) ? ROWS : SNAP_ROWS;

    state_t              state_reg, state_next;
    cells_t              occ_reg [ROWS];
    cells_t              occ_next [ROWS];
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                one_col_reg, one_col_next;
    logic [3:0]          h_reg, h_next;
    logic                keep_reg, keep_next;
    logic [3:0]          run0_reg, run0_next, run1_reg, run1_next;
    logic [CNT_W-1:0]    st0_reg, st0_next, st1_reg, st1_next;
    logic                hit_reg, hit_next;
    logic [SPAN_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    cells_t              mask_reg, mask_next;
    logic [1:0]          res_col_reg, res_col_next;
    logic [3:0]          res_row_reg, res_row_next;
    logic                out_valid_reg, out_valid_next;
    logic                found_reg, found_next;
    logic [1:0]          out_column_reg, out_column_next;
    logic [3:0]          out_row_reg, out_row_next;
    logic [15:0]         snap_reg, snap_next;

    logic                accept;
    logic                last_row;
    logic                out_free;
    logic                scan_hit;
    logic                reserve_ok;
    cells_t              head;
    cells_t              head_new;
    logic [SPAN_W-1:0]   cnt_span;
    logic [3:0]          run0_inc, run1_inc;
    logic [15:0]         snap_now;

    assign accept     = in_valid && in_ready;
    assign last_row   = (cnt_reg == CNT_W'(ROWS - 1));
    assign out_free   = !out_valid_reg || out_ready;
    assign head       = occ_reg[0];
    assign cnt_span   = SPAN_W'(cnt_reg);
    assign run0_inc   = run0_reg + 4'd1;
    assign run1_inc   = run1_reg + 4'd1;
    assign reserve_ok = (col_first <= col_last) && (row_first <= row_last);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (func_t'(func) == FUNC_FIND)
                        state_next = ST_SCAN;
                    else if (func_t'(func) == FUNC_RESERVE && reserve_ok)
                        state_next = ST_MARK;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (last_row)
                    state_next = (scan_hit && keep_reg) ? ST_MARK : ST_DONE;
            end
            ST_MARK:
            begin
                if (last_row)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
    end

    // current map image as seen from the head
    always_comb
    begin
        snap_now = '0;
        for (int unsigned r = 0; r < SNAP_N; r++)
            snap_now[2*r +: 2] = occ_reg[r];
    end

    // datapath
    always_comb
    begin
        cnt_next     = cnt_reg;
        one_col_next = one_col_reg;
        h_next       = h_reg;
        keep_next    = keep_reg;
        run0_next    = run0_reg;
        run1_next    = run1_reg;
        st0_next     = st0_reg;
        st1_next     = st1_reg;
        hit_next     = hit_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mask_next    = mask_reg;
        res_col_next = res_col_reg;
        res_row_next = res_row_reg;
        head_new     = head;
        scan_hit     = hit_reg;

        for (int unsigned i = 0; i + 1 < ROWS; i++)
            occ_next[i] = occ_reg[i + 1];
        occ_next[ROWS-1] = head;

        unique case (state_reg)
            ST_IDLE:
            begin
                for (int unsigned i = 0; i < ROWS; i++)
                    occ_next[i] = occ_reg[i];
                if (accept)
                begin
                    cnt_next     = '0;
                    one_col_next = (req_columns == 2'd1);
                    h_next       = (req_rows >= 4'd1 && req_rows <= 4'(MAX_HEIGHT))
                                   ? req_rows : 4'(DEFAULT_HEIGHT);
                    keep_next    = reserve_on_find;
                    run0_next    = '0;
                    run1_next    = '0;
                    st0_next     = '0;
                    st1_next     = '0;
                    hit_next     = 1'b0;
                    res_col_next = '0;
                    res_row_next = '0;
                    lo_next      = SPAN_W'(row_first);
                    hi_next      = SPAN_W'(row_last);
                    mask_next    = {col_last, !col_first};
                    unique case (func_t'(func))
                        FUNC_CLEAR:
                        begin
                            for (int unsigned i = 0; i < ROWS; i++)
                                occ_next[i] = '0;
                        end
                        FUNC_FIND:
                        begin
                            res_col_next = (req_columns == 2'd1) ? 2'd1 : 2'(NUM_COLS);
                            res_row_next = (req_rows >= 4'd1 && req_rows <= 4'(MAX_HEIGHT))
                                           ? req_rows : 4'(DEFAULT_HEIGHT);
                        end
                        FUNC_RESERVE: ;
                        FUNC_NONE: ;
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cnt_next = last_row ? '0 : cnt_reg + CNT_W'(1);
                if (!hit_reg)
                begin
                    if (one_col_reg)
                    begin
                        // column 0 first, it wins a tie on the same row
                        if (!head[0])
                        begin
                            run0_next = run0_inc;
                            if (run0_reg == 4'd0)
                                st0_next = cnt_reg;
                            if (run0_inc == h_reg)
                            begin
                                scan_hit     = 1'b1;
                                res_col_next = 2'd1;
                                res_row_next = 4'(st0_next) + 4'd1;
                                mask_next    = 2'b01;
                                lo_next      = SPAN_W'(st0_next);
                            end
                        end
                        else
                            run0_next = '0;
                        if (!scan_hit)
                        begin
                            if (!head[1])
                            begin
                                run1_next = run1_inc;
                                if (run1_reg == 4'd0)
                                    st1_next = cnt_reg;
                                if (run1_inc == h_reg)
                                begin
                                    scan_hit     = 1'b1;
                                    res_col_next = 2'd2;
                                    res_row_next = 4'(st1_next) + 4'd1;
                                    mask_next    = 2'b10;
                                    lo_next      = SPAN_W'(st1_next);
                                end
                            end
                            else
                                run1_next = '0;
                        end
                    end
                    else
                    begin
                        if (head == 2'b00)
                        begin
                            run0_next = run0_inc;
                            if (run0_reg == 4'd0)
                                st0_next = cnt_reg;
                            if (run0_inc == h_reg)
                            begin
                                scan_hit     = 1'b1;
                                res_col_next = 2'd1;
                                res_row_next = 4'(st0_next) + 4'd1;
                                mask_next    = 2'b11;
                                lo_next      = SPAN_W'(st0_next);
                            end
                        end
                        else
                            run0_next = '0;
                    end
                    hi_next  = lo_next + SPAN_W'(h_reg) - SPAN_W'(1);
                    hit_next = scan_hit;
                end
            end
            ST_MARK:
            begin
                cnt_next = last_row ? '0 : cnt_reg + CNT_W'(1);
                if (cnt_span >= lo_reg && cnt_span <= hi_reg)
                    head_new = head | mask_reg;
                occ_next[ROWS-1] = head_new;
            end
            ST_DONE:
            begin
                for (int unsigned i = 0; i < ROWS; i++)
                    occ_next[i] = occ_reg[i];
            end
            default: ;
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        found_next      = found_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        snap_next       = snap_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next  = 1'b1;
            found_next      = hit_reg;
            out_column_next = res_col_reg;
            out_row_next    = res_row_reg;
            snap_next       = snap_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            for (int unsigned i = 0; i < ROWS; i++)
                occ_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            for (int unsigned i = 0; i < ROWS; i++)
                occ_reg[i] <= occ_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        one_col_reg    <= one_col_next;
        h_reg          <= h_next;
        keep_reg       <= keep_next;
        run0_reg       <= run0_next;
        run1_reg       <= run1_next;
        st0_reg        <= st0_next;
        st1_reg        <= st1_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mask_reg       <= mask_next;
        res_col_reg    <= res_col_next;
        res_row_reg    <= res_row_next;
        found_reg      <= found_next;
        out_column_reg <= out_column_next;
        out_row_reg    <= out_row_next;
        snap_reg       <= snap_next;
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign out_column   = out_column_reg;
    assign out_row      = out_row_reg;
    assign map_snapshot = snap_reg;

endmodule
`default_nettype wire
